### hdl/rlmp_pkg.sv
// Shared types and constants for the radio link message parser.
`default_nettype none

package rlmp_pkg;

    localparam logic [7:0] CHAR_S          = 8'h53;
    localparam logic [7:0] CHAR_V          = 8'h56;
    localparam logic [7:0] CHAR_C          = 8'h43;
    localparam logic [7:0] CHAR_R          = 8'h52;
    localparam logic [7:0] CHAR_ONE        = 8'h31;
    localparam logic [7:0] LINK_MODE_RESET = 8'h58;

    localparam logic [3:0] SCAN_LEN   = 4'd5;
    localparam logic [3:0] ID_LEN     = 4'd4;
    localparam logic [3:0] RSSI_COUNT = 4'd9;

    localparam int unsigned PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_LINK_MODE = 3'd0;

    typedef enum logic [1:0] {
        FRAME_NONE = 2'd0,
        FRAME_ID   = 2'd1,
        FRAME_SCAN = 2'd2,
        FRAME_RSSI = 2'd3
    } frame_kind_t;

    typedef enum logic [1:0] {
        EV_ECHO = 2'd0,
        EV_ID   = 2'd1,
        EV_SCAN = 2'd2,
        EV_RSSI = 2'd3
    } event_kind_t;

    typedef struct packed {
        logic              has;
        event_kind_t       kind;
        logic [7:0]        echo_byte;
        logic [31:0]       cube_id;
        logic [7:0]        cube_type;
        logic [3:0]        rssi_index;
        logic signed [7:0] rssi_value;
        logic              rssi_last;
    } result_t;

endpackage

`default_nettype wire

### hdl/rlmp_core.sv
// Parse state and per-byte step logic of the radio link message parser.
`default_nettype none

module rlmp_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic             cmd,
    input  wire logic [7:0]       rx_byte,
    input  wire logic [7:0]       link_mode,
    output rlmp_pkg::result_t     result
);

    rlmp_pkg::frame_kind_t frame_kind_reg, frame_kind_next;
    logic [3:0]  bytes_left_reg, bytes_left_next;
    logic [31:0] id_accum_reg, id_accum_next;
    logic [7:0]  type_hold_reg, type_hold_next;
    logic [3:0]  sample_index_reg, sample_index_next;

    logic        scan_mode;
    logic [3:0]  bl_dec;
    logic [31:0] id_lane;
    logic [31:0] id_merged;

    assign scan_mode = (link_mode >= rlmp_pkg::CHAR_S) && (link_mode <= rlmp_pkg::CHAR_V);
    assign bl_dec    = bytes_left_reg - 4'd1;
    // Place the byte in the lane picked by the remaining count (big-endian).
    assign id_lane   = {24'd0, rx_byte} << {bl_dec[1:0], 3'b000};
    assign id_merged = (bl_dec < 4'd4) ? (id_accum_reg | id_lane) : id_accum_reg;

    // Next parse state.
    always_comb
    begin
        frame_kind_next   = frame_kind_reg;
        bytes_left_next   = bytes_left_reg;
        id_accum_next     = id_accum_reg;
        type_hold_next    = type_hold_reg;
        sample_index_next = sample_index_reg;
        if (step)
        begin
            if (cmd)
            begin
                frame_kind_next = rlmp_pkg::FRAME_NONE;
                bytes_left_next = 4'd0;
            end
            else if (bytes_left_reg == 4'd0)
            begin
                frame_kind_next = rlmp_pkg::FRAME_NONE;
                if (scan_mode)
                begin
                    if (rx_byte == rlmp_pkg::CHAR_S)
                    begin
                        frame_kind_next = rlmp_pkg::FRAME_SCAN;
                        bytes_left_next = rlmp_pkg::SCAN_LEN;
                        id_accum_next   = 32'd0;
                        type_hold_next  = 8'd0;
                    end
                end
                else if (rx_byte == rlmp_pkg::CHAR_C)
                begin
                    frame_kind_next = rlmp_pkg::FRAME_ID;
                    bytes_left_next = rlmp_pkg::ID_LEN;
                    id_accum_next   = 32'd0;
                end
                else if (rx_byte == rlmp_pkg::CHAR_R)
                begin
                    frame_kind_next   = rlmp_pkg::FRAME_RSSI;
                    bytes_left_next   = rlmp_pkg::RSSI_COUNT;
                    sample_index_next = 4'd0;
                end
            end
            else
            begin
                bytes_left_next = bl_dec;
                unique case (frame_kind_reg)
                    rlmp_pkg::FRAME_ID:
                    begin
                        id_accum_next = id_merged;
                        if (bl_dec == 4'd0)
                            frame_kind_next = rlmp_pkg::FRAME_NONE;
                    end
                    rlmp_pkg::FRAME_SCAN:
                    begin
                        if (bl_dec >= 4'd4)
                            type_hold_next = rx_byte;
                        else
                            id_accum_next = id_merged;
                        if (bl_dec == 4'd0)
                            frame_kind_next = rlmp_pkg::FRAME_NONE;
                    end
                    rlmp_pkg::FRAME_RSSI:
                    begin
                        sample_index_next = sample_index_reg + 4'd1;
                        if (bl_dec == 4'd0)
                            frame_kind_next = rlmp_pkg::FRAME_NONE;
                    end
                    rlmp_pkg::FRAME_NONE:
                    begin
                        bytes_left_next = 4'd0;
                    end
                    default:
                    begin
                        bytes_left_next = 4'd0;
                    end
                endcase
            end
        end
    end

    // Result of the current request.
    always_comb
    begin
        result = '0;
        if (step && !cmd)
        begin
            if (bytes_left_reg == 4'd0)
            begin
                if (!scan_mode && (rx_byte == rlmp_pkg::CHAR_ONE))
                begin
                    result.has       = 1'b1;
                    result.kind      = rlmp_pkg::EV_ECHO;
                    result.echo_byte = link_mode;
                end
            end
            else
            begin
                unique case (frame_kind_reg)
                    rlmp_pkg::FRAME_ID:
                    begin
                        if (bl_dec == 4'd0)
                        begin
                            result.has     = 1'b1;
                            result.kind    = rlmp_pkg::EV_ID;
                            result.cube_id = id_merged;
                        end
                    end
                    rlmp_pkg::FRAME_SCAN:
                    begin
                        if (bl_dec == 4'd0)
                        begin
                            result.has       = 1'b1;
                            result.kind      = rlmp_pkg::EV_SCAN;
                            result.cube_id   = id_merged;
                            result.cube_type = type_hold_reg;
                        end
                    end
                    rlmp_pkg::FRAME_RSSI:
                    begin
                        result.has        = 1'b1;
                        result.kind       = rlmp_pkg::EV_RSSI;
                        result.rssi_index = sample_index_reg;
                        result.rssi_value = rx_byte;
                        result.rssi_last  = (bl_dec == 4'd0);
                    end
                    default:
                    begin
                        result.has = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_kind_reg   <= rlmp_pkg::FRAME_NONE;
            bytes_left_reg   <= 4'd0;
            id_accum_reg     <= 32'd0;
            type_hold_reg    <= 8'd0;
            sample_index_reg <= 4'd0;
        end
        else
        begin
            frame_kind_reg   <= frame_kind_next;
            bytes_left_reg   <= bytes_left_next;
            id_accum_reg     <= id_accum_next;
            type_hold_reg    <= type_hold_next;
            sample_index_reg <= sample_index_next;
        end
    end

    // An open frame always has bytes pending, and an idle parser has none.
    a_kind_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_kind_reg == rlmp_pkg::FRAME_NONE) == (bytes_left_reg == 4'd0))
        else $error("frame kind and byte count disagree");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (bytes_left_reg <= rlmp_pkg::SCAN_LEN) || (bytes_left_reg <= rlmp_pkg::RSSI_COUNT))
        else $error("byte count beyond longest frame");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (result.has && result.rssi_last) |=> (frame_kind_reg == rlmp_pkg::FRAME_NONE))
        else $error("last rssi sample left frame open");

endmodule

`default_nettype wire

### hdl/radio_link_message_parser.sv
// Top level of the radio link message parser: request pipe, result register, APB port.
`default_nettype none

// Takes one request (purge or received byte) per cycle and gives at most one
// result per request. A request is held in the input register, is parsed by
// short logic against the frame state, and its result lands in the output
// register; a new request is taken every cycle while results are taken. The
// output register keeps in_ready high while a result waits, as long as the
// input register is free. link_mode sits at APB address 0 (reset 'X'); write
// it only when no request is in flight.
module radio_link_message_parser (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          cmd,
    input  wire logic [7:0]                    rx_byte,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         event_kind,
    output logic [7:0]                         echo_byte,
    output logic [31:0]                        cube_id,
    output logic [7:0]                         cube_type,
    output logic [3:0]                         rssi_index,
    output logic signed [7:0]                  rssi_value,
    output logic                               rssi_last,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rlmp_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic        in_valid_reg;
    logic        cmd_reg;
    logic [7:0]  byte_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [7:0]  link_mode_reg;
    logic        advance;
    logic        cfg_write;

    rlmp_pkg::result_t result;
    rlmp_pkg::result_t result_reg;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == rlmp_pkg::ADDR_LINK_MODE);
    assign prdata    = (paddr == rlmp_pkg::ADDR_LINK_MODE) ? {24'd0, link_mode_reg} : 32'd0;

    rlmp_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .cmd       (cmd_reg),
        .rx_byte   (byte_reg),
        .link_mode (link_mode_reg),
        .result    (result)
    );

    always_comb
    begin
        if (advance)
            out_valid_next = result.has;
        else
            out_valid_next = out_valid_reg && !out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            link_mode_reg <= rlmp_pkg::LINK_MODE_RESET;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
                link_mode_reg <= pwdata[7:0];
        end
    end

    // Payload registers: load on a fresh request or a result that produces output.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg  <= cmd;
            byte_reg <= rx_byte;
        end
        if (advance && result.has)
            result_reg <= result;
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = 2'(result_reg.kind);
    assign echo_byte  = result_reg.echo_byte;
    assign cube_id    = result_reg.cube_id;
    assign cube_type  = result_reg.cube_type;
    assign rssi_index = result_reg.rssi_index;
    assign rssi_value = result_reg.rssi_value;
    assign rssi_last  = result_reg.rssi_last;

    a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(cmd_reg) && $stable(byte_reg)))
        else $error("stalled request dropped or changed");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a waiting result");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(result_reg)))
        else $error("waiting result overwritten");

endmodule

`default_nettype wire

### tb/tb_radio_link_message_parser.sv
// Self-checking testbench for the radio link message parser: directed frames plus random traffic.
`timescale 1ns / 1ps

module tb_radio_link_message_parser;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          cmd = 1'b0;
    logic [7:0]                    rx_byte = 8'd0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [1:0]                    event_kind;
    logic [7:0]                    echo_byte;
    logic [31:0]                   cube_id;
    logic [7:0]                    cube_type;
    logic [3:0]                    rssi_index;
    logic signed [7:0]             rssi_value;
    logic                          rssi_last;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [rlmp_pkg::PADDR_W-1:0]  paddr = '0;
    logic [31:0]                   pwdata = 32'd0;
    logic [31:0]                   prdata;
    logic                          pready;

    radio_link_message_parser dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_kind (event_kind),
        .echo_byte  (echo_byte),
        .cube_id    (cube_id),
        .cube_type  (cube_type),
        .rssi_index (rssi_index),
        .rssi_value (rssi_value),
        .rssi_last  (rssi_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 clk = ~clk;

    // Parser state as the testbench tracks it
    logic [7:0]             mode_now = rlmp_pkg::LINK_MODE_RESET;
    rlmp_pkg::frame_kind_t  frame_now = rlmp_pkg::FRAME_NONE;
    logic [3:0]             left_now = 4'd0;
    logic [31:0]            id_now = 32'd0;
    logic [7:0]             type_now = 8'd0;
    logic [3:0]             sample_now = 4'd0;

    rlmp_pkg::result_t      report_q[$];
    rlmp_pkg::result_t      want;
    int                     mismatches = 0;
    int                     work_count = 0;
    int                     send_idle_pct = 0;
    int                     recv_stall_pct = 0;

    function automatic bit is_scan_mode(input logic [7:0] m);
        return (m >= rlmp_pkg::CHAR_S) && (m <= rlmp_pkg::CHAR_V);
    endfunction

    // Advance the tracked state by one request; return 0 when the request is dropped.
    function automatic bit parse_request(input logic c, input logic [7:0] b);
        rlmp_pkg::result_t r;
        bit busy;
        r = '0;
        if (c)
        begin
            busy = (left_now != 4'd0);
            left_now = 4'd0;
            frame_now = rlmp_pkg::FRAME_NONE;
            return busy;
        end
        if (left_now == 4'd0)
        begin
            frame_now = rlmp_pkg::FRAME_NONE;
            if (is_scan_mode(mode_now))
            begin
                if (b != rlmp_pkg::CHAR_S)
                    return 0;
                frame_now = rlmp_pkg::FRAME_SCAN;
                left_now = rlmp_pkg::SCAN_LEN;
                id_now = 32'd0;
                type_now = 8'd0;
                return 1;
            end
            if (b == rlmp_pkg::CHAR_C)
            begin
                frame_now = rlmp_pkg::FRAME_ID;
                left_now = rlmp_pkg::ID_LEN;
                id_now = 32'd0;
            end
            else if (b == rlmp_pkg::CHAR_R)
            begin
                frame_now = rlmp_pkg::FRAME_RSSI;
                left_now = rlmp_pkg::RSSI_COUNT;
                sample_now = 4'd0;
            end
            else if (b == rlmp_pkg::CHAR_ONE)
            begin
                r.kind = rlmp_pkg::EV_ECHO;
                r.echo_byte = mode_now;
                report_q.push_back(r);
            end
            else
                return 0;
            return 1;
        end
        left_now = left_now - 4'd1;
        case (frame_now)
            rlmp_pkg::FRAME_ID:
            begin
                if (left_now < 4'd4)
                    id_now = id_now | ({24'd0, b} << (8 * left_now));
                if (left_now == 4'd0)
                begin
                    r.kind = rlmp_pkg::EV_ID;
                    r.cube_id = id_now;
                    report_q.push_back(r);
                    frame_now = rlmp_pkg::FRAME_NONE;
                end
            end
            rlmp_pkg::FRAME_SCAN:
            begin
                if (left_now >= 4'd4)
                    type_now = b;
                else
                    id_now = id_now | ({24'd0, b} << (8 * left_now));
                if (left_now == 4'd0)
                begin
                    r.kind = rlmp_pkg::EV_SCAN;
                    r.cube_id = id_now;
                    r.cube_type = type_now;
                    report_q.push_back(r);
                    frame_now = rlmp_pkg::FRAME_NONE;
                end
            end
            rlmp_pkg::FRAME_RSSI:
            begin
                r.kind = rlmp_pkg::EV_RSSI;
                r.rssi_index = sample_now;
                r.rssi_value = b;
                r.rssi_last = (left_now == 4'd0);
                report_q.push_back(r);
                sample_now = sample_now + 4'd1;
                if (left_now == 4'd0)
                    frame_now = rlmp_pkg::FRAME_NONE;
            end
            default:
                left_now = 4'd0;
        endcase
        return 1;
    endfunction

    // Receiver: random stalls, and compare every accepted result with the oldest report.
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (report_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: kind %0d id %h", event_kind, cube_id);
            end
            else
            begin
                want = report_q.pop_front();
                if (event_kind !== want.kind || echo_byte !== want.echo_byte
                    || cube_id !== want.cube_id || cube_type !== want.cube_type
                    || rssi_index !== want.rssi_index || rssi_value !== want.rssi_value
                    || rssi_last !== want.rssi_last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch (exp/got): kind %0d/%0d echo %h/%h id %h/%h ",
                                  "type %h/%h idx %0d/%0d val %0d/%0d last %b/%b"},
                                 want.kind, event_kind, want.echo_byte, echo_byte,
                                 want.cube_id, cube_id, want.cube_type, cube_type,
                                 want.rssi_index, rssi_index, want.rssi_value, rssi_value,
                                 want.rssi_last, rssi_last);
                end
            end
        end
    end

    task automatic send_req(input logic c, input logic [7:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        rx_byte <= b;
        do @(posedge clk); while (!in_ready);
        work_count += parse_request(c, b);
    endtask

    // Drop valid, wait for every report, then let any request without a result drain.
    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (report_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_link_mode(input logic [7:0] m);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= rlmp_pkg::ADDR_LINK_MODE;
        pwdata <= {24'd0, m};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        mode_now = m;
        // read back in a second transfer
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[7:0] !== m)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("link_mode read back: exp %h got %h", m, prdata[7:0]);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [7:0] rand_data();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 8'h00;
        if (r < 10)
            return 8'hFF;
        if (r < 18)
            case ($urandom_range(3))
                0: return rlmp_pkg::CHAR_S;
                1: return rlmp_pkg::CHAR_C;
                2: return rlmp_pkg::CHAR_R;
                default: return rlmp_pkg::CHAR_ONE;
            endcase
        return 8'($urandom_range(255));
    endfunction

    // Start byte plus payload; now and then purge partway through.
    task automatic send_frame(input logic [7:0] start, input int len);
        int i;
        send_req(1'b0, start);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 4)
                send_req(1'b1, rand_data());
            send_req(1'b0, rand_data());
        end
    endtask

    task automatic gen_sequence();
        int r;
        r = $urandom_range(99);
        if (is_scan_mode(mode_now))
        begin
            if (r < 70)
                send_frame(rlmp_pkg::CHAR_S, rlmp_pkg::SCAN_LEN);
            else if (r < 80)
                send_req(1'b0, 8'($urandom_range(255)));
            else if (r < 88)
                send_req(1'b1, rand_data());
            else if (r < 95)
                case ($urandom_range(2))
                    0: send_req(1'b0, rlmp_pkg::CHAR_C);
                    1: send_req(1'b0, rlmp_pkg::CHAR_R);
                    default: send_req(1'b0, rlmp_pkg::CHAR_ONE);
                endcase
            else
                send_frame(rlmp_pkg::CHAR_S, $urandom_range(1, rlmp_pkg::SCAN_LEN - 1));
        end
        else
        begin
            if (r < 30)
                send_frame(rlmp_pkg::CHAR_C, rlmp_pkg::ID_LEN);
            else if (r < 60)
                send_frame(rlmp_pkg::CHAR_R, rlmp_pkg::RSSI_COUNT);
            else if (r < 70)
                send_req(1'b0, rlmp_pkg::CHAR_ONE);
            else if (r < 78)
                send_req(1'b0, 8'($urandom_range(255)));
            else if (r < 86)
                send_req(1'b1, rand_data());
            else if (r < 93)
                send_frame(rlmp_pkg::CHAR_C, $urandom_range(1, rlmp_pkg::ID_LEN - 1));
            else
                send_frame(rlmp_pkg::CHAR_R, $urandom_range(1, rlmp_pkg::RSSI_COUNT - 1));
        end
    endtask

    task automatic test_reset_mode();
        send_req(1'b0, rlmp_pkg::CHAR_ONE);
        send_req(1'b0, 8'h5A);
        wait_results_done();
    endtask

    // Id frame opened in normal mode keeps its framing across a switch to scan mode.
    task automatic test_id_mode_change();
        send_req(1'b0, rlmp_pkg::CHAR_C);
        send_req(1'b0, 8'h00);
        send_req(1'b0, 8'h00);
        wait_results_done();
        set_link_mode(rlmp_pkg::CHAR_V);
        send_req(1'b0, 8'h00);
        send_req(1'b0, 8'h00);
        wait_results_done();
    endtask

    task automatic test_rssi_extremes();
        set_link_mode(8'h00);
        send_req(1'b0, rlmp_pkg::CHAR_R);
        send_req(1'b0, 8'h80);
        send_req(1'b0, 8'h7F);
        send_req(1'b0, 8'h00);
        send_req(1'b0, 8'hFF);
        send_req(1'b0, 8'h01);
        send_req(1'b0, 8'hFE);
        send_req(1'b0, rlmp_pkg::CHAR_R);
        send_req(1'b0, rlmp_pkg::CHAR_S);
        send_req(1'b0, rlmp_pkg::CHAR_ONE);
        wait_results_done();
    endtask

    task automatic test_scan_frame();
        set_link_mode(rlmp_pkg::CHAR_S);
        send_req(1'b0, rlmp_pkg::CHAR_S);
        send_req(1'b0, 8'h00);
        send_req(1'b0, 8'hFF);
        send_req(1'b0, 8'hFF);
        send_req(1'b0, 8'hFF);
        send_req(1'b0, 8'hFF);
        wait_results_done();
    endtask

    task automatic test_purge();
        send_req(1'b0, rlmp_pkg::CHAR_S);
        send_req(1'b1, 8'hFF);
        send_req(1'b1, 8'h00);
        wait_results_done();
    endtask

    task automatic test_random_traffic(input int sidle, input int rstall, input int base);
        logic [7:0] mode_list[9];
        int sub;
        mode_list = '{rlmp_pkg::CHAR_S, rlmp_pkg::LINK_MODE_RESET, 8'h00, rlmp_pkg::CHAR_V,
                      8'hFF, 8'h55, rlmp_pkg::CHAR_R, 8'h57, 8'h00};
        send_idle_pct = sidle;
        recv_stall_pct = rstall;
        for (sub = 0; sub < 4; sub++)
        begin
            if ((base + sub) % 9 == 8)
                set_link_mode(8'($urandom_range(255)));
            else
                set_link_mode(mode_list[(base + sub) % 9]);
            work_count = 0;
            while (work_count < 84)
                gen_sequence();
            wait_results_done();
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct = 12;
        recv_stall_pct = 76;
        test_reset_mode();
        test_id_mode_change();
        test_rssi_extremes();
        test_scan_frame();
        test_purge();
        test_random_traffic(12, 76, 0);
        test_random_traffic(76, 12, 4);
        test_random_traffic(0, 0, 8);
        wait_results_done();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && report_q.size() == 0)
            $display("[radio_link_message_parser] OK");
        else
            $display("[radio_link_message_parser] ERROR");
        $finish;
    end

    initial
    begin
        #400000;
        $display("[radio_link_message_parser] ERROR");
        $finish;
    end

endmodule
